// ----- rtl/core/cartesian_to_polar_degrees_macros.svh -----
// Assertion helpers shared by the converter modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CARTESIAN_TO_POLAR_DEGREES_MACROS_SVH
`define CARTESIAN_TO_POLAR_DEGREES_MACROS_SVH

// Same-cycle implication.
`define C2P_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define C2P_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/cart2pol_pkg.sv -----
package cart2pol_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int RADIUS_WIDTH = 16;
    localparam int ANGLE_WIDTH  = 15;
    localparam int ROOT_BITS    = 16;
    localparam int SUM_WIDTH    = 32;
    localparam int GUARD_BITS   = 16;
    localparam int CX_WIDTH     = COORD_WIDTH + GUARD_BITS + 3;
    localparam int Z_WIDTH      = 25;
    localparam int ZC_WIDTH     = 24;
    localparam int ATAN_IDX_W   = 5;

    localparam logic [ZC_WIDTH-1:0]    DEG90_Q16     = 24'd5898240;
    localparam logic [ZC_WIDTH-1:0]    ROUND_HALF_Q6 = 24'd512;
    localparam logic [ANGLE_WIDTH-1:0] FULL_TURN_Q6  = 15'd23040;
    localparam logic [ANGLE_WIDTH-1:0] HALF_TURN_Q6  = 15'd11520;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
    } cart2pol_in_t;

    typedef struct packed {
        logic [RADIUS_WIDTH-1:0] radius;
        logic [ANGLE_WIDTH-1:0]  angle_deg;
    } cart2pol_out_t;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic zero;
    } cart2pol_flags_t;

    // Working set that flows through the iteration stages: square-root
    // remainder and partial root, CORDIC vector and angle accumulator.
    typedef struct packed {
        logic [SUM_WIDTH-1:0]       rem;
        logic [ROOT_BITS-1:0]       root;
        logic signed [CX_WIDTH-1:0] cx;
        logic signed [CX_WIDTH-1:0] cy;
        logic signed [Z_WIDTH-1:0]  cz;
        cart2pol_flags_t            flags;
    } cart2pol_iter_t;

    // atan(2^-i) in degrees, Q.16, rounded to nearest.
    function automatic logic signed [Z_WIDTH-1:0] atan_deg_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_WIDTH-1:0] val;
        case (idx)
            5'd0:    val = 25'sd2949120;
            5'd1:    val = 25'sd1740967;
            5'd2:    val = 25'sd919879;
            5'd3:    val = 25'sd466945;
            5'd4:    val = 25'sd234379;
            5'd5:    val = 25'sd117304;
            5'd6:    val = 25'sd58666;
            5'd7:    val = 25'sd29335;
            5'd8:    val = 25'sd14668;
            5'd9:    val = 25'sd7334;
            5'd10:   val = 25'sd3667;
            5'd11:   val = 25'sd1833;
            5'd12:   val = 25'sd917;
            5'd13:   val = 25'sd458;
            5'd14:   val = 25'sd229;
            5'd15:   val = 25'sd115;
            5'd16:   val = 25'sd57;
            5'd17:   val = 25'sd29;
            5'd18:   val = 25'sd14;
            5'd19:   val = 25'sd7;
            5'd20:   val = 25'sd4;
            5'd21:   val = 25'sd2;
            5'd22:   val = 25'sd1;
            default: val = 25'sd0;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/core/cart2pol_pre.sv -----
module cart2pol_pre (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cart2pol_pkg::cart2pol_in_t  in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cart2pol_pkg::cart2pol_iter_t out_data
);
    import cart2pol_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic ready1, ready2, ready3;

    logic [COORD_WIDTH-1:0] ax1_reg, ay1_reg, ax1_next, ay1_next;
    cart2pol_flags_t        flags1_reg, flags1_next;

    logic [COORD_WIDTH-1:0] ax2_reg, ay2_reg;
    logic [SUM_WIDTH-1:0]   sqx_reg, sqy_reg, sqx_next, sqy_next;
    cart2pol_flags_t        flags2_reg;

    cart2pol_iter_t         iter_reg, iter_next;

    assign ready3   = !v3_reg || out_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    // Magnitudes fit unsigned in the coordinate width, including the most
    // negative input.
    always_comb
    begin
        flags1_next.x_neg = in_data.x_coord[COORD_WIDTH-1];
        flags1_next.y_neg = in_data.y_coord[COORD_WIDTH-1];
        flags1_next.zero  = (in_data.x_coord == '0) && (in_data.y_coord == '0);
        ax1_next = flags1_next.x_neg ? (~in_data.x_coord + 1'b1) : in_data.x_coord;
        ay1_next = flags1_next.y_neg ? (~in_data.y_coord + 1'b1) : in_data.y_coord;
    end

    always_comb
    begin
        sqx_next = SUM_WIDTH'(ax1_reg) * SUM_WIDTH'(ax1_reg);
        sqy_next = SUM_WIDTH'(ay1_reg) * SUM_WIDTH'(ay1_reg);
    end

    always_comb
    begin
        iter_next.rem   = sqx_reg + sqy_reg;
        iter_next.root  = '0;
        iter_next.cx    = CX_WIDTH'({ax2_reg, {GUARD_BITS{1'b0}}});
        iter_next.cy    = CX_WIDTH'({ay2_reg, {GUARD_BITS{1'b0}}});
        iter_next.cz    = '0;
        iter_next.flags = flags2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            ax1_reg    <= ax1_next;
            ay1_reg    <= ay1_next;
            flags1_reg <= flags1_next;
        end
        if (ready2 && v1_reg)
        begin
            ax2_reg    <= ax1_reg;
            ay2_reg    <= ay1_reg;
            sqx_reg    <= sqx_next;
            sqy_reg    <= sqy_next;
            flags2_reg <= flags1_reg;
        end
        if (ready3 && v2_reg)
        begin
            iter_reg <= iter_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = iter_reg;

endmodule

// ----- rtl/core/cart2pol_stage.sv -----
module cart2pol_stage #(
    parameter int SHIFT     = 0,
    parameter bit DO_ROOT   = 1'b1,
    parameter bit DO_CORDIC = 1'b1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cart2pol_pkg::cart2pol_iter_t in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output cart2pol_pkg::cart2pol_iter_t out_data
);
    import cart2pol_pkg::*;

    // Root bit decided here, most significant first.
    localparam int ROOT_BIT = DO_ROOT ? (ROOT_BITS - 1 - SHIFT) : 0;
    localparam logic [ATAN_IDX_W-1:0] ATAN_IDX = ATAN_IDX_W'(SHIFT);

    logic                       valid_reg;
    cart2pol_iter_t             data_reg, data_next;
    logic [SUM_WIDTH+1:0]       trial;
    logic                       fits;
    logic signed [CX_WIDTH-1:0] dx, dy;
    logic signed [Z_WIDTH-1:0]  dz;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
        trial = ((SUM_WIDTH + 2)'(in_data.root) << (ROOT_BIT + 1))
              + ((SUM_WIDTH + 2)'(1) << (2 * ROOT_BIT));
        fits  = {2'b00, in_data.rem} >= trial;
        dx    = in_data.cx >>> SHIFT;
        dy    = in_data.cy >>> SHIFT;
        dz    = atan_deg_q16(ATAN_IDX);

        data_next = in_data;
        if (DO_ROOT && fits)
        begin
            data_next.rem  = in_data.rem - trial[SUM_WIDTH-1:0];
            data_next.root = in_data.root | (ROOT_BITS'(1) << ROOT_BIT);
        end
        if (DO_CORDIC)
        begin
            if (!in_data.cy[CX_WIDTH-1])
            begin
                data_next.cx = in_data.cx + dy;
                data_next.cy = in_data.cy - dx;
                data_next.cz = in_data.cz + dz;
            end
            else
            begin
                data_next.cx = in_data.cx - dy;
                data_next.cy = in_data.cy + dx;
                data_next.cz = in_data.cz - dz;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/core/cart2pol_post.sv -----
`include "cartesian_to_polar_degrees_macros.svh"

module cart2pol_post (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cart2pol_pkg::cart2pol_iter_t in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output cart2pol_pkg::cart2pol_out_t  out_data
);
    import cart2pol_pkg::*;

    logic                      valid_reg;
    cart2pol_out_t             data_reg, data_next;
    logic [ZC_WIDTH-1:0]       z_clamped;
    logic [ZC_WIDTH-1:0]       z_rounded;
    logic [ANGLE_WIDTH-1:0]    t_quad;
    logic [ANGLE_WIDTH-1:0]    angle_raw;
    logic [RADIUS_WIDTH:0]     root_up;

    assign in_ready = !valid_reg || !out_stall;

    always_comb
    begin
        if (in_data.cz[Z_WIDTH-1])
        begin
            z_clamped = '0;
        end
        else if (in_data.cz[ZC_WIDTH-1:0] > DEG90_Q16)
        begin
            z_clamped = DEG90_Q16;
        end
        else
        begin
            z_clamped = in_data.cz[ZC_WIDTH-1:0];
        end
        z_rounded = (z_clamped + ROUND_HALF_Q6) >> 10;
        t_quad    = z_rounded[ANGLE_WIDTH-1:0];

        case ({in_data.flags.y_neg, in_data.flags.x_neg})
            2'b00:   angle_raw = t_quad;
            2'b01:   angle_raw = HALF_TURN_Q6 - t_quad;
            2'b11:   angle_raw = HALF_TURN_Q6 + t_quad;
            2'b10:   angle_raw = FULL_TURN_Q6 - t_quad;
            default: angle_raw = t_quad;
        endcase

        if (in_data.flags.zero)
        begin
            data_next.angle_deg = '0;
        end
        else if (angle_raw >= FULL_TURN_Q6)
        begin
            data_next.angle_deg = angle_raw - FULL_TURN_Q6;
        end
        else
        begin
            data_next.angle_deg = angle_raw;
        end

        // Round to nearest: the remainder is s - q^2.
        root_up = {1'b0, in_data.root}
                + (RADIUS_WIDTH + 1)'(in_data.rem > SUM_WIDTH'(in_data.root));
        data_next.radius = root_up[RADIUS_WIDTH] ? '1 : root_up[RADIUS_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `C2P_CHECK(zero_radius_zero_angle, out_valid && out_data.radius == '0, out_data.angle_deg == '0, "zero radius with nonzero angle")
    `C2P_CHECK(angle_below_full_turn, out_valid, out_data.angle_deg < FULL_TURN_Q6, "angle not wrapped below a full turn")
    `C2P_CHECK_NEXT(taken_result_clears, out_valid && !out_stall && !in_valid, !out_valid, "delivered result repeated")

endmodule

// ----- rtl/core/cartesian_to_polar_degrees.sv -----
// Pipeline from input transaction to result: three front-end stages, one iteration stage per root bit
// or CORDIC step, one output stage.
// Throughput: one transaction per cycle; every stage is a register with its own valid bit,
// so bubbles close up and the input is stalled only when all stages hold data and the output waits.
// Reset clears every valid bit and sets the enable register to 1; no clearing pass is needed.
`include "cartesian_to_polar_degrees_macros.svh"

module cartesian_to_polar_degrees #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  cart2pol_pkg::cart2pol_in_t  in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output cart2pol_pkg::cart2pol_out_t out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);
    import cart2pol_pkg::*;

    localparam int DEPTH = (CORDIC_STAGES > ROOT_BITS) ? CORDIC_STAGES : ROOT_BITS;

    logic           enable_reg, enable_next;
    logic           pre_ready;
    cart2pol_iter_t chain_data  [DEPTH+1];
    logic [DEPTH:0] chain_valid;
    logic [DEPTH:0] chain_ready;

    assign cfg_ready   = 1'b1;
    assign enable_next = (cfg_valid && cfg_ready) ? cfg_data : enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else
        begin
            enable_reg <= enable_next;
        end
    end

    // A transaction taken while disabled enters as a bubble.
    assign in_stall = !pre_ready;

    cart2pol_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid && enable_reg),
        .in_ready  (pre_ready),
        .in_data   (in_data),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_iter
        cart2pol_stage #(
            .SHIFT     (k),
            .DO_ROOT   (k < ROOT_BITS),
            .DO_CORDIC (k < CORDIC_STAGES)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    cart2pol_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[DEPTH]),
        .in_ready  (chain_ready[DEPTH]),
        .in_data   (chain_data[DEPTH]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `C2P_CHECK(stall_only_when_output_blocked, in_stall, out_valid && out_stall, "input stalled while output free")
    `C2P_CHECK(empty_output_frees_input, !out_valid, !in_stall, "input stalled with empty output register")

endmodule

// ----- tb/sv/cartesian_to_polar_degrees_tb.sv -----
module cartesian_to_polar_degrees_tb;

    import cart2pol_pkg::*;

    localparam int  DRAIN_CYCLES = 40;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  RUN_LIMIT    = 3000000;
    localparam bit  POLAR_OFF    = 1'b0;
    localparam bit  POLAR_ON     = 1'b1;

    // Predicts radius and angle for each coordinate pair accepted while conversion is enabled and keeps
    // the predictions in arrival order until the block delivers them.
    class polar_scoreboard;
        bit            polar_on;
        cart2pol_out_t pending_polar[$];
        int            errors;
        int            pairs_converted;
        int            pairs_dropped;
        int            results_checked;

        function new();
            polar_on = POLAR_ON;
            errors = 0;
            pairs_converted = 0;
            pairs_dropped = 0;
            results_checked = 0;
        endfunction

        function void set_enable(bit on);
            polar_on = on;
        endfunction

        function int pending();
            return pending_polar.size();
        endfunction

        function longint atan_step_q16(int i);
            case (i)
                0:       return 2949120;
                1:       return 1740967;
                2:       return 919879;
                3:       return 466945;
                4:       return 234379;
                5:       return 117304;
                6:       return 58666;
                7:       return 29335;
                8:       return 14668;
                9:       return 7334;
                10:      return 3667;
                11:      return 1833;
                12:      return 917;
                13:      return 458;
                14:      return 229;
                15:      return 115;
                default: return 0;
            endcase
        endfunction

        // Integer square root, then rounded to nearest.
        function longint rounded_root(longint sum_sq);
            longint q;
            longint b;
            q = 0;
            for (int k = 31; k >= 0; k--) begin
                b = longint'(1) << k;
                if ((q + b) * (q + b) <= sum_sq)
                    q += b;
            end
            if (sum_sq - q * q > q)
                q++;
            return q;
        endfunction

        // Vectoring CORDIC on the folded vector; result in Q.6 degrees.
        function longint first_quadrant_q6(longint ax, longint ay);
            longint cx;
            longint cy;
            longint cz;
            longint nx;
            longint ny;
            cx = ax <<< GUARD_BITS;
            cy = ay <<< GUARD_BITS;
            cz = 0;
            for (int i = 0; i < 16; i++) begin
                if (cy >= 0) begin
                    nx = cx + (cy >>> i);
                    ny = cy - (cx >>> i);
                    cz += atan_step_q16(i);
                end
                else begin
                    nx = cx - (cy >>> i);
                    ny = cy + (cx >>> i);
                    cz -= atan_step_q16(i);
                end
                cx = nx;
                cy = ny;
            end
            if (cz < 0)
                cz = 0;
            if (cz > longint'(DEG90_Q16))
                cz = longint'(DEG90_Q16);
            return (cz + 512) >>> 10;
        endfunction

        function void note_input(cart2pol_in_t item);
            longint        x;
            longint        y;
            longint        ax;
            longint        ay;
            longint        r;
            longint        t;
            longint        a;
            cart2pol_out_t polar;
            if (!polar_on) begin
                pairs_dropped++;
                return;
            end
            x = $signed(item.x_coord);
            y = $signed(item.y_coord);
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            r = rounded_root(ax * ax + ay * ay);
            if (r > 65535)
                r = 65535;
            if (ax == 0 && ay == 0) begin
                a = 0;
            end
            else begin
                t = first_quadrant_q6(ax, ay);
                if (y >= 0)
                    a = (x >= 0) ? t : longint'(HALF_TURN_Q6) - t;
                else
                    a = (x < 0) ? longint'(HALF_TURN_Q6) + t : longint'(FULL_TURN_Q6) - t;
                if (a >= longint'(FULL_TURN_Q6))
                    a -= longint'(FULL_TURN_Q6);
            end
            polar.radius = r[RADIUS_WIDTH-1:0];
            polar.angle_deg = a[ANGLE_WIDTH-1:0];
            pending_polar.push_back(polar);
            pairs_converted++;
        endfunction

        function void check_result(cart2pol_out_t got);
            cart2pol_out_t want;
            if (pending_polar.size() == 0) begin
                $error("unexpected transaction: radius %0d angle_deg %0d",
                       got.radius, got.angle_deg);
                errors++;
                return;
            end
            want = pending_polar.pop_front();
            results_checked++;
            if (got.radius !== want.radius) begin
                $error("radius: expected %0d, actual %0d", want.radius, got.radius);
                errors++;
            end
            if (got.angle_deg !== want.angle_deg) begin
                $error("angle_deg: expected %0d, actual %0d", want.angle_deg, got.angle_deg);
                errors++;
            end
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    cart2pol_in_t  in_data;
    logic          out_valid;
    logic          out_stall;
    cart2pol_out_t out_data;
    logic          cfg_valid;
    logic          cfg_ready;
    logic          cfg_data;

    polar_scoreboard sb = new();
    int              burst_left = 0;
    bit              hold_req = 1'b0;

    cartesian_to_polar_degrees dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    // Output side: switches between stall patterns, and on request holds off
    // long enough for the whole pipeline to back up into the input.
    initial
    begin : receiver
        int mode;
        int left;
        mode = 0;
        left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 150);
                end
                left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 99) < 30);
                    2:       out_stall <= ($urandom_range(0, 99) < 75);
                    default: out_stall <= ((left % 4) == 0);
                endcase
            end
        end
    end

    task automatic send_point(input int x, input int y);
        cart2pol_in_t item;
        item.x_coord = x[COORD_WIDTH-1:0];
        item.y_coord = y[COORD_WIDTH-1:0];
        @(negedge clk);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (in_stall);
        sb.note_input(item);
    endtask

    task automatic send_random(input int count);
        int x;
        int y;
        int m;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    x = $signed(16'($urandom));
                    y = $signed(16'($urandom));
                end
                4: begin
                    x = int'($urandom_range(0, 128)) - 64;
                    y = int'($urandom_range(0, 128)) - 64;
                end
                5: begin
                    x = $signed(16'($urandom));
                    y = 0;
                    if ($urandom_range(0, 1)) begin
                        y = x;
                        x = 0;
                    end
                end
                6: begin
                    m = $urandom_range(0, 32767);
                    x = $urandom_range(0, 1) ? m : -m;
                    y = $urandom_range(0, 1) ? m : -m;
                end
                7: begin
                    // Close to the positive x axis, where the angle may wrap.
                    x = $urandom_range(1, 32767);
                    y = int'($urandom_range(0, 6)) - 3;
                end
                default: begin
                    x = int'($urandom_range(0, 4095)) - 2048;
                    y = int'($urandom_range(0, 4095)) - 2048;
                end
            endcase
            send_point(x, y);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(input bit on);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= on;
        do @(posedge clk); while (!cfg_ready);
        sb.set_enable(on);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_directed();
        send_point(0, 0);
        send_point(32767, 0);
        send_point(-32768, 0);
        send_point(0, 32767);
        send_point(0, -32768);
        send_point(32767, 32767);
        send_point(-32768, -32768);
        send_point(-32768, 32767);
        send_point(32767, -32768);
        send_point(32767, -1);
        send_point(-32768, -1);
        send_point(-32768, 1);
        send_point(1, -32768);
        send_point(16, 16);
        send_point(-16, 16);
        send_point(-16, -16);
        send_point(16, -16);
        send_point(1, 0);
        send_point(0, -1);
        send_point(-1, 0);
        send_point(1, -1);
        send_point(3, -4);
        send_point(-1, 2);
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_directed();
        hold_req = 1'b1;
        send_random(500);
        settle();

        write_enable(POLAR_OFF);
        send_random(120);
        settle();

        write_enable(POLAR_ON);
        send_point(0, 0);
        send_point(32767, -1);
        hold_req = 1'b1;
        send_random(480);
        settle();

        $display("Converted %0d coordinate pairs, checked %0d results; %0d pairs sent",
                 sb.pairs_converted, sb.results_checked, sb.pairs_dropped);
        $display("while conversion was disabled, with output hold-offs and varied stalls.");
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/cart2pol_pkg.sv
rtl/core/cart2pol_pre.sv
rtl/core/cart2pol_stage.sv
rtl/core/cart2pol_post.sv
rtl/core/cartesian_to_polar_degrees.sv
tb/sv/cartesian_to_polar_degrees_tb.sv
